[sv/sbad_pkg.sv]
// shared types and constants of the system bus address decoder
package sbad_pkg;

    // cartridge size is a power of two, so the modulo is a mask
    localparam int CART_BYTES = 2097152;
    localparam int RAM_BYTES  = 4096;
    localparam int RAM_AW     = $clog2(RAM_BYTES);

    localparam logic [23:0] CART_MASK   = 24'(CART_BYTES - 1);
    localparam logic [23:0] ROM_TOP     = 24'h000FFF;
    localparam logic [23:0] RAM_TOP     = 24'h001FFF;
    localparam logic [23:0] REG_TOP     = 24'h0020FF;
    localparam logic [7:0]  FIXED_VALUE = 8'h10;

    // device codes as reported on the result channel
    typedef enum logic [3:0] {
        TGT_ROM    = 4'd0,
        TGT_RAM    = 4'd1,
        TGT_CTRL   = 4'd2,
        TGT_RTC    = 4'd3,
        TGT_IRQ    = 4'd4,
        TGT_TIM256 = 4'd5,
        TGT_KEYS   = 4'd6,
        TGT_GPIO   = 4'd7,
        TGT_SOUND  = 4'd8,
        TGT_BLIT   = 4'd9,
        TGT_LCD    = 4'd10,
        TGT_TIMERS = 4'd11,
        TGT_FIXED  = 4'd12,
        TGT_CART   = 4'd13,
        TGT_NONE   = 4'd14
    } target_t;

    // where the open-bus latch takes its next value from
    typedef enum logic [1:0] {
        SRC_KEEP  = 2'd0,
        SRC_WRITE = 2'd1,
        SRC_RAM   = 2'd2,
        SRC_EXT   = 2'd3
    } lsrc_t;

    // configuration register indexes
    localparam logic CFG_DISPLAY = 1'b0;
    localparam logic CFG_CART    = 1'b1;

    // decode of one byte address
    typedef struct packed {
        target_t     target;
        logic [23:0] taddr;
        logic        strobe;
        lsrc_t       src;
    } dec_t;

    // one byte access handed to the result stage
    typedef struct packed {
        target_t     target;
        logic [23:0] taddr;
        logic        strobe;
        logic [7:0]  wbyte;
        logic [7:0]  ext;
        lsrc_t       src;
        logic        last;
    } bytecmd_t;

endpackage

[sv/sbad_decode.sv]
// byte address decoder: target, target address, write strobe and latch source
module sbad_decode (
    input  logic              [23:0] addr,
    input  logic                     wr,
    input  logic                     display_en,
    input  logic                     cart_en,
    output sbad_pkg::dec_t           dec
);

    logic [7:0]        off;
    sbad_pkg::target_t reg_tgt;

    assign off = addr[7:0];

    // device map inside the register window
    always_comb begin
        reg_tgt = sbad_pkg::TGT_NONE;
        priority if (off <= 8'h02) begin
            reg_tgt = sbad_pkg::TGT_CTRL;
        end else if (off >= 8'h08 && off <= 8'h0B) begin
            reg_tgt = sbad_pkg::TGT_RTC;
        end else if (off >= 8'h20 && off <= 8'h2A) begin
            reg_tgt = sbad_pkg::TGT_IRQ;
        end else if (off >= 8'h40 && off <= 8'h41) begin
            reg_tgt = sbad_pkg::TGT_TIM256;
        end else if (off >= 8'h50 && off <= 8'h55) begin
            reg_tgt = sbad_pkg::TGT_KEYS;
        end else if (off >= 8'h60 && off <= 8'h62) begin
            reg_tgt = sbad_pkg::TGT_GPIO;
        end else if (off >= 8'h70 && off <= 8'h71) begin
            reg_tgt = sbad_pkg::TGT_SOUND;
        end else if (off == 8'h10) begin
            reg_tgt = wr ? sbad_pkg::TGT_NONE : sbad_pkg::TGT_FIXED;
        end else if (off >= 8'hFE) begin
            reg_tgt = display_en ? sbad_pkg::TGT_LCD : sbad_pkg::TGT_NONE;
        end else if (wr && off >= 8'h80 && off <= 8'h8A) begin
            reg_tgt = sbad_pkg::TGT_BLIT;
        end else if (!wr && ((off >= 8'h80 && off <= 8'h8F) ||
                             (off >= 8'hF0 && off <= 8'hF8))) begin
            reg_tgt = sbad_pkg::TGT_BLIT;
        end else if ((off >= 8'h18 && off <= 8'h1D) || (off >= 8'h30 && off <= 8'h3F) ||
                     (off >= 8'h48 && off <= 8'h4F)) begin
            reg_tgt = sbad_pkg::TGT_TIMERS;
        end else begin
            reg_tgt = sbad_pkg::TGT_NONE;
        end
    end

    // top-level map, strobe and latch source
    always_comb begin
        dec.taddr = addr;
        priority if (addr <= sbad_pkg::ROM_TOP) begin
            dec.target = sbad_pkg::TGT_ROM;
        end else if (addr <= sbad_pkg::RAM_TOP) begin
            dec.target = sbad_pkg::TGT_RAM;
            dec.taddr  = {{(24 - sbad_pkg::RAM_AW){1'b0}}, addr[sbad_pkg::RAM_AW-1:0]};
        end else if (addr <= sbad_pkg::REG_TOP) begin
            dec.target = reg_tgt;
        end else if (cart_en) begin
            dec.target = sbad_pkg::TGT_CART;
            dec.taddr  = addr & sbad_pkg::CART_MASK;
        end else begin
            dec.target = sbad_pkg::TGT_NONE;
        end

        dec.strobe = wr && (dec.target != sbad_pkg::TGT_ROM) &&
                     (dec.target != sbad_pkg::TGT_NONE);

        priority if (wr) begin
            dec.src = sbad_pkg::SRC_WRITE;
        end else if (dec.target == sbad_pkg::TGT_RAM) begin
            dec.src = sbad_pkg::SRC_RAM;
        end else if (dec.target == sbad_pkg::TGT_NONE) begin
            dec.src = sbad_pkg::SRC_KEEP;
        end else begin
            dec.src = sbad_pkg::SRC_EXT;
        end
    end

endmodule

[sv/sbad_ram.sv]
// 4 KiB work ram, one write or read per cycle, registered read data
module sbad_ram (
    input  logic                          aclk,
    input  logic                          we,
    input  logic                          re,
    input  logic [sbad_pkg::RAM_AW-1:0]   addr,
    input  logic [7:0]                    wdata,
    output logic [7:0]                    rdata
);

    logic [7:0] mem [sbad_pkg::RAM_BYTES];
    logic [7:0] rdata_reg;

    // storage and read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/sbad_result.sv]
// result stage: open-bus latch update and the result output register
module sbad_result (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 issue_valid,
    input  sbad_pkg::bytecmd_t   issue,
    output logic                 issue_ready,
    input  logic [7:0]           ram_rdata,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_target,
    output logic [23:0]          m_target_address,
    output logic                 m_is_write,
    output logic [7:0]           m_write_byte,
    output logic [7:0]           m_read_byte,
    output logic                 m_last
);

    logic               b_valid_reg;
    sbad_pkg::bytecmd_t b_reg;
    logic               out_valid_reg;
    sbad_pkg::bytecmd_t out_reg;
    logic [7:0]         out_read_reg;
    logic [7:0]         latch_reg;
    logic [7:0]         latch_next;
    logic               out_free;
    logic               b_adv;

    assign out_free    = !out_valid_reg || m_ready;
    assign b_adv       = b_valid_reg && out_free;
    assign issue_ready = !b_valid_reg || b_adv;

    // new latch value; ram data is valid the cycle after the read
    always_comb begin
        unique case (b_reg.src)
            sbad_pkg::SRC_KEEP:  latch_next = latch_reg;
            sbad_pkg::SRC_WRITE: latch_next = b_reg.wbyte;
            sbad_pkg::SRC_RAM:   latch_next = ram_rdata;
            sbad_pkg::SRC_EXT:   latch_next = b_reg.ext;
            default:             latch_next = latch_reg;
        endcase
    end

    // byte stage and output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_reg     <= 8'd0;
        end else begin
            if (issue_valid && issue_ready) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                out_valid_reg <= 1'b1;
                latch_reg     <= latch_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (issue_valid && issue_ready) begin
            b_reg <= issue;
        end
        if (b_adv) begin
            out_reg      <= b_reg;
            out_read_reg <= latch_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_target         = out_reg.target;
    assign m_target_address = out_reg.taddr;
    assign m_is_write       = out_reg.strobe;
    assign m_write_byte     = out_reg.wbyte;
    assign m_read_byte      = out_read_reg;
    assign m_last           = out_reg.last;

endmodule

[sv/system_bus_address_decoder_unit.sv]
// top level of the system bus address decoder with work ram and open-bus latch
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    func, bus_address, write_word, external bytes
//  m_       out        m_valid/m_ready    target, target_address, is_write, bytes, last
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data (bit 0)
//
//  a byte access is one byte, a word access two; one byte per cycle, unless m_ready
//  stalls, goes through the single ram port and the open-bus latch. a byte passes the
//  input, byte stage and output registers. reset clears the latch and both enables;
//  ram contents are undefined until written and get no clearing pass. a stalled result
//  holds in the output register while the next byte waits in the byte stage.
module system_bus_address_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [23:0] s_bus_address,
    input  logic [15:0] s_write_word,
    input  logic [7:0]  s_external_low_byte,
    input  logic [7:0]  s_external_high_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_target,
    output logic [23:0] m_target_address,
    output logic        m_is_write,
    output logic [7:0]  m_write_byte,
    output logic [7:0]  m_read_byte,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    logic               display_en_reg;
    logic               cart_en_reg;
    logic               in_valid_reg;
    logic               phase_reg;
    logic [1:0]         func_reg;
    logic [23:0]        addr_reg;
    logic [15:0]        wword_reg;
    logic [7:0]         elo_reg;
    logic [7:0]         ehi_reg;
    logic               wr;
    logic               byte_last;
    logic               a_adv;
    logic               issue_ready;
    logic [23:0]        cur_addr;
    logic [7:0]         cur_wdata;
    logic [7:0]         cur_ext;
    sbad_pkg::dec_t     dec;
    sbad_pkg::bytecmd_t issue;
    logic [7:0]         ram_rdata;
    logic               ram_hit;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_en_reg <= 1'b0;
            cart_en_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sbad_pkg::CFG_DISPLAY: display_en_reg <= cfg_data;
                sbad_pkg::CFG_CART:    cart_en_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // input register and byte sequencing
    assign wr        = func_reg[0];
    assign byte_last = !func_reg[1] || phase_reg;
    assign a_adv     = in_valid_reg && issue_ready;
    assign s_ready   = !in_valid_reg || (a_adv && byte_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                phase_reg    <= 1'b0;
            end else if (a_adv) begin
                if (byte_last) begin
                    in_valid_reg <= 1'b0;
                end else begin
                    phase_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            addr_reg  <= s_bus_address;
            wword_reg <= s_write_word;
            elo_reg   <= s_external_low_byte;
            ehi_reg   <= s_external_high_byte;
        end
    end

    // current byte: second byte wraps inside its 64 KiB bank
    assign cur_addr  = phase_reg ? {addr_reg[23:16], addr_reg[15:0] + 16'd1} : addr_reg;
    assign cur_wdata = phase_reg ? wword_reg[15:8] : wword_reg[7:0];
    assign cur_ext   = phase_reg ? ehi_reg : elo_reg;

    sbad_decode u_decode (
        .addr       (cur_addr),
        .wr         (wr),
        .display_en (display_en_reg),
        .cart_en    (cart_en_reg),
        .dec        (dec)
    );

    // byte command for the result stage
    always_comb begin
        issue.target = dec.target;
        issue.taddr  = dec.taddr;
        issue.strobe = dec.strobe;
        issue.wbyte  = wr ? cur_wdata : 8'd0;
        issue.ext    = (dec.target == sbad_pkg::TGT_FIXED) ? sbad_pkg::FIXED_VALUE : cur_ext;
        issue.src    = dec.src;
        issue.last   = byte_last;
    end

    // ram access is issued as the byte moves to the result stage
    assign ram_hit = a_adv && (dec.target == sbad_pkg::TGT_RAM);

    sbad_ram u_ram (
        .aclk  (aclk),
        .we    (ram_hit && wr),
        .re    (ram_hit && !wr),
        .addr  (dec.taddr[sbad_pkg::RAM_AW-1:0]),
        .wdata (cur_wdata),
        .rdata (ram_rdata)
    );

    sbad_result u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .issue_valid      (a_adv),
        .issue            (issue),
        .issue_ready      (issue_ready),
        .ram_rdata        (ram_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_target         (m_target),
        .m_target_address (m_target_address),
        .m_is_write       (m_is_write),
        .m_write_byte     (m_write_byte),
        .m_read_byte      (m_read_byte),
        .m_last           (m_last)
    );

`ifndef SYNTHESIS
    // the first byte of a word is followed by its second byte
    a_word_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_adv && func_reg[1] && !phase_reg) |=> (in_valid_reg && phase_reg))
        else $error("word access lost its second byte");

    // no new item while a word is half done
    a_no_accept_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && func_reg[1] && !phase_reg) |-> !s_ready)
        else $error("item accepted in the middle of a word access");

    // write strobes never go to rom or to nothing
    a_strobe_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_write) |->
        (m_target != sbad_pkg::TGT_ROM && m_target != sbad_pkg::TGT_NONE))
        else $error("write strobe to rom or unmapped target");

    // ram results carry an offset inside the ram
    a_ram_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_target == sbad_pkg::TGT_RAM) |-> (m_target_address[23:12] == 12'd0))
        else $error("ram offset out of range");
`endif

endmodule
